/* sv/bldc_pkg.sv */
// Package for the single-button LED dimmer controller.
// Holds the item types, the operation and register codes and the duty mapping.
// No dependencies.
package bldc_pkg;

  // Operation codes carried in an input item.
  localparam logic [1:0] OP_CONTROL = 2'd0;
  localparam logic [1:0] OP_DIM     = 2'd1;
  localparam logic [1:0] OP_TIMER   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd0;
  localparam logic [1:0] REG_DIM_OFFSET    = 2'd1;
  localparam logic [1:0] REG_MIN_DUTY      = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] TIMEOUT_LIMIT_RST = 8'h80;
  localparam logic [6:0] DIM_OFFSET_RST    = 7'd32;
  localparam logic [7:0] MIN_DUTY_RST      = 8'd1;

  localparam logic [7:0] DUTY_MAX  = 8'hFF;
  localparam logic [7:0] LEVEL_MAX = 8'hFF;

  // Lamp modes, encoded as they appear on the mode output field.
  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_WAIT1   = 3'd1,
    MODE_WAIT2   = 3'd2,
    MODE_WAIT3   = 3'd3,
    MODE_ON      = 3'd4,
    MODE_DIM     = 3'd5,
    MODE_DIMWAIT = 3'd6
  } mode_e;

  // One input item.
  typedef struct packed {
    logic [1:0] op;
    logic       button_pressed;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] duty;
    logic       led_enabled;
    logic       deep_sleep;
  } out_item_t;

  // Map the dimming level to a PWM duty: a dead zone at or below the offset
  // gives the minimum duty, the top band saturates, and the rest is shifted.
  function automatic logic [7:0] map_duty(logic [7:0] lvl, logic [6:0] off,
                                          logic [7:0] mind);
    logic [8:0] sum;
    sum = {1'b0, lvl} - {2'b00, off} + {1'b0, mind};
    if (lvl <= {1'b0, off}) begin
      return mind;
    end else if (lvl >= (DUTY_MAX - {1'b0, off})) begin
      return DUTY_MAX;
    end else if (sum[8]) begin
      return DUTY_MAX;
    end else begin
      return sum[7:0];
    end
  endfunction

endpackage

/* sv/button_led_dimmer_control_unit.sv */
// Top level of the single-button LED dimmer controller.
// Depends on bldc_pkg for item types, codes and the duty mapping.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o  | in_data_i  (bldc_pkg::in_item_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (bldc_pkg::out_item_t)
//   cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// The state and the output register are both updated at the accepting edge,
// so an item's result is visible in the cycle after it is accepted.
// One item is accepted per cycle while the output register is empty or being
// taken; a stalled result holds the input off until it is taken.
// Reset (rst_ni low) is asynchronous; there is no clearing pass.
module button_led_dimmer_control_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bldc_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bldc_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [7:0]           cfg_data_i
);

  // Configuration registers.
  logic [7:0] timeout_limit_q;
  logic [6:0] dim_offset_q;
  logic [7:0] min_duty_q;

  // Lamp state.
  bldc_pkg::mode_e mode_q, mode_d;
  logic       ramp_up_q, ramp_up_d;
  logic [7:0] level_q, level_d;
  logic [7:0] duty_q, duty_d;
  logic [7:0] count_q, count_d;
  logic       pending_q, pending_d;
  logic       deep_sleep_q, deep_sleep_d;
  logic       led_q, led_d;

  // Result register.
  logic                out_valid_q;
  bldc_pkg::out_item_t out_data_q;

  logic            in_accept;
  bldc_pkg::mode_e ctrl_mode;
  logic            btn;
  logic [7:0]      count_inc;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign btn         = in_data_i.button_pressed;
  assign count_inc   = (count_q == timeout_limit_q) ? 8'd0 : count_q + 8'd1;

  // Next mode of a control pass; a pending timeout overrides the button in every mode but ON and DIM.
  always_comb begin
    ctrl_mode = mode_q;
    unique case (mode_q)
      bldc_pkg::MODE_OFF: begin
        if (btn) ctrl_mode = bldc_pkg::MODE_WAIT1;
        if (pending_q) ctrl_mode = bldc_pkg::MODE_OFF;
      end
      bldc_pkg::MODE_WAIT1: begin
        if (!btn) ctrl_mode = bldc_pkg::MODE_WAIT2;
        if (pending_q) ctrl_mode = bldc_pkg::MODE_OFF;
      end
      bldc_pkg::MODE_WAIT2: begin
        if (btn) ctrl_mode = bldc_pkg::MODE_WAIT3;
        if (pending_q) ctrl_mode = bldc_pkg::MODE_OFF;
      end
      bldc_pkg::MODE_WAIT3: begin
        if (!btn) ctrl_mode = bldc_pkg::MODE_ON;
        if (pending_q) ctrl_mode = bldc_pkg::MODE_OFF;
      end
      bldc_pkg::MODE_ON: begin
        if (btn) ctrl_mode = bldc_pkg::MODE_DIMWAIT;
      end
      bldc_pkg::MODE_DIMWAIT: begin
        if (!btn) ctrl_mode = bldc_pkg::MODE_OFF;
        if (pending_q) ctrl_mode = bldc_pkg::MODE_DIM;
      end
      bldc_pkg::MODE_DIM: begin
        if (!btn) ctrl_mode = bldc_pkg::MODE_ON;
      end
      default: ctrl_mode = mode_q;
    endcase
  end

  // State update for one accepted item, with the entry actions of a new mode.
  always_comb begin
    mode_d       = mode_q;
    ramp_up_d    = ramp_up_q;
    level_d      = level_q;
    duty_d       = duty_q;
    count_d      = count_q;
    pending_d    = pending_q;
    deep_sleep_d = deep_sleep_q;
    led_d        = led_q;
    if (in_accept) begin
      unique case (in_data_i.op)
        bldc_pkg::OP_CONTROL: begin
          pending_d = 1'b0;
          mode_d    = ctrl_mode;
          if (ctrl_mode != mode_q) begin
            unique case (ctrl_mode)
              bldc_pkg::MODE_OFF: begin
                deep_sleep_d = 1'b1;
                duty_d       = 8'd0;
                led_d        = 1'b0;
                count_d      = 8'd0;
              end
              bldc_pkg::MODE_WAIT1: begin
                count_d      = 8'd0;
                deep_sleep_d = 1'b0;
              end
              bldc_pkg::MODE_WAIT2, bldc_pkg::MODE_WAIT3,
              bldc_pkg::MODE_DIMWAIT: begin
                count_d = 8'd0;
              end
              bldc_pkg::MODE_ON: begin
                duty_d = bldc_pkg::map_duty(level_q, dim_offset_q, min_duty_q);
                led_d  = 1'b1;
              end
              default: begin
                count_d = count_q;
              end
            endcase
          end
        end
        bldc_pkg::OP_DIM: begin
          // Triangle sweep of the level, only while dimming.
          if (mode_q == bldc_pkg::MODE_DIM) begin
            if (ramp_up_q) begin
              level_d = level_q + 8'd1;
              if (level_d == bldc_pkg::LEVEL_MAX) ramp_up_d = 1'b0;
            end else begin
              level_d = level_q - 8'd1;
              if (level_d == 8'd0) ramp_up_d = 1'b1;
            end
            duty_d = bldc_pkg::map_duty(level_d, dim_offset_q, min_duty_q);
          end
        end
        bldc_pkg::OP_TIMER: begin
          count_d = count_inc;
          if (count_inc == timeout_limit_q) pending_d = 1'b1;
        end
        default: begin
          pending_d = pending_q;
        end
      endcase
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_limit_q <= bldc_pkg::TIMEOUT_LIMIT_RST;
      dim_offset_q    <= bldc_pkg::DIM_OFFSET_RST;
      min_duty_q      <= bldc_pkg::MIN_DUTY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bldc_pkg::REG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_data_i;
        bldc_pkg::REG_DIM_OFFSET:    dim_offset_q    <= cfg_data_i[6:0];
        bldc_pkg::REG_MIN_DUTY:      min_duty_q      <= cfg_data_i;
        default:                     min_duty_q      <= min_duty_q;
      endcase
    end
  end

  // Lamp state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= bldc_pkg::MODE_OFF;
      ramp_up_q    <= 1'b1;
      level_q      <= 8'd0;
      duty_q       <= 8'd0;
      count_q      <= 8'd0;
      pending_q    <= 1'b0;
      deep_sleep_q <= 1'b1;
      led_q        <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      ramp_up_q    <= ramp_up_d;
      level_q      <= level_d;
      duty_q       <= duty_d;
      count_q      <= count_d;
      pending_q    <= pending_d;
      deep_sleep_q <= deep_sleep_d;
      led_q        <= led_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload shows the state after the accepted item.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q.mode        <= mode_d;
      out_data_q.duty        <= duty_d;
      out_data_q.led_enabled <= led_d;
      out_data_q.deep_sleep  <= deep_sleep_d;
    end
  end

endmodule

/* sv/bldc_checker.sv */
// Port-level checker for the single-button LED dimmer controller.
// Depends on bldc_pkg; bound to button_led_dimmer_control_unit below.
module bldc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bldc_pkg::out_item_t out_data_o
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Every accepted item yields a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item gave no result");

  // The input is never held off while the result register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // Off means dark, zero duty and power-down sleep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mode == bldc_pkg::MODE_OFF |->
      !out_data_o.led_enabled && out_data_o.duty == 8'd0 && out_data_o.deep_sleep)
    else $error("off mode with lamp state active");

  // The lit modes always drive the LED.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.mode == bldc_pkg::MODE_ON ||
                    out_data_o.mode == bldc_pkg::MODE_DIM ||
                    out_data_o.mode == bldc_pkg::MODE_DIMWAIT) |->
      out_data_o.led_enabled)
    else $error("lit mode without LED drive");

endmodule

bind button_led_dimmer_control_unit bldc_checker u_bldc_checker (.*);
